FILE: src/trd_pkg.sv
// Shared types and codes for the TLS record deframer.
// Used by trd_core, trd_skid and tls_record_deframer; no dependencies.
package trd_pkg;

   // Result event codes
   localparam logic [1:0] EV_HEADER  = 2'd0;
   localparam logic [1:0] EV_PAYLOAD = 2'd1;
   localparam logic [1:0] EV_ERROR   = 2'd2;

   // Error codes
   localparam logic [1:0] ERR_NONE     = 2'd0;
   localparam logic [1:0] ERR_TYPE     = 2'd1;
   localparam logic [1:0] ERR_VERSION  = 2'd2;
   localparam logic [1:0] ERR_OVERFLOW = 2'd3;

   // Header layout and limits
   localparam logic [2:0] HEADER_BYTES = 3'd5;
   localparam logic [7:0] TYPE_MIN     = 8'h14;
   localparam logic [7:0] TYPE_MAX     = 8'h17;
   localparam logic [7:0] VERSION_MAJ  = 8'd3;
   localparam logic [7:0] VERSION_MIN  = 8'd3;

   // Configuration register map
   localparam int          ROOM_WIDTH = 17;
   localparam logic [16:0] ROOM_RESET = 17'd18480;
   localparam logic [0:0]  REG_BUFFER_ROOM = 1'b0;

   // One result item
   typedef struct packed {
      logic [1:0]  event_res;
      logic [7:0]  payload_byte;
      logic [1:0]  record_type;
      logic [15:0] record_length;
      logic        last;
      logic [1:0]  error_code;
   } result_type;

endpackage

FILE: src/trd_core.sv
// Record header gathering, checking and payload counting for one byte per cycle while accept is high.
// Depends on trd_pkg for the result struct and codes.
module trd_core #(
   parameter int ROOM_MARGIN = 48
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic [7:0]            stream_byte,
   input  logic [16:0]           buffer_room,
   output trd_pkg::result_type   result
);

   localparam logic [16:0] MARGIN = 17'(ROOM_MARGIN);

   logic [2:0]  header_count_ff, header_count_in;
   logic [7:0]  header_type_ff, header_type_in;
   logic [7:0]  header_major_ff, header_major_in;
   logic [7:0]  header_minor_ff, header_minor_in;
   logic [15:0] header_length_ff, header_length_in;
   logic [15:0] payload_count_ff, payload_count_in;
   logic [1:0]  error_ff, error_in;

   logic [15:0] payload_next;
   logic [16:0] room_need;
   logic [1:0]  check_err;
   logic [7:0]  type_offset;

   // Gather header bytes into the fields
   always_comb begin
      header_type_in   = header_type_ff;
      header_major_in  = header_major_ff;
      header_minor_in  = header_minor_ff;
      header_length_in = header_length_ff;
      case (header_count_ff)
         3'd0: begin
            header_type_in = stream_byte;
         end
         3'd1: begin
            header_major_in = stream_byte;
         end
         3'd2: begin
            header_minor_in = stream_byte;
         end
         3'd3: begin
            header_length_in = {stream_byte, 8'd0};
         end
         3'd4: begin
            header_length_in = {header_length_ff[15:8], stream_byte};
         end
         default: begin
            header_length_in = header_length_ff;
         end
      endcase
   end

   // Check the completed header: type, then version, then room
   assign room_need = {1'b0, header_length_in} + MARGIN;
   always_comb begin
      if (header_type_in < trd_pkg::TYPE_MIN || header_type_in > trd_pkg::TYPE_MAX) begin
         check_err = trd_pkg::ERR_TYPE;
      end else if (header_major_in < trd_pkg::VERSION_MAJ ||
                   (header_major_in == trd_pkg::VERSION_MAJ &&
                    header_minor_in < trd_pkg::VERSION_MIN)) begin
         check_err = trd_pkg::ERR_VERSION;
      end else if (room_need >= buffer_room) begin
         check_err = trd_pkg::ERR_OVERFLOW;
      end else begin
         check_err = trd_pkg::ERR_NONE;
      end
   end

   assign payload_next = payload_count_ff + 16'd1;
   assign type_offset  = header_type_in - trd_pkg::TYPE_MIN;

   // Build the result and the next state
   always_comb begin
      header_count_in  = header_count_ff;
      payload_count_in = payload_count_ff;
      error_in         = error_ff;
      result.event_res     = trd_pkg::EV_HEADER;
      result.payload_byte  = 8'd0;
      result.record_type   = type_offset[1:0];
      result.record_length = header_length_in;
      result.last          = 1'b0;
      result.error_code    = trd_pkg::ERR_NONE;
      if (error_ff != trd_pkg::ERR_NONE) begin
         // Sticky error: ignore the byte
         result.event_res  = trd_pkg::EV_ERROR;
         result.error_code = error_ff;
      end else if (header_count_ff < trd_pkg::HEADER_BYTES) begin
         header_count_in = header_count_ff + 3'd1;
         if (header_count_ff != trd_pkg::HEADER_BYTES - 3'd1) begin
            result.record_type   = 2'd0;
            result.record_length = 16'd0;
         end else if (check_err != trd_pkg::ERR_NONE) begin
            error_in          = check_err;
            result.event_res  = trd_pkg::EV_ERROR;
            result.error_code = check_err;
         end else begin
            payload_count_in = 16'd0;
            // Empty record completes at the header end
            if (header_length_in == 16'd0) begin
               header_count_in = 3'd0;
               result.last     = 1'b1;
            end
         end
      end else begin
         result.event_res    = trd_pkg::EV_PAYLOAD;
         result.payload_byte = stream_byte;
         payload_count_in    = payload_next;
         if (payload_next >= header_length_ff) begin
            header_count_in  = 3'd0;
            payload_count_in = 16'd0;
            result.last      = 1'b1;
         end
      end
   end

   // Advance state on each accepted request
   always_ff @(posedge clock) begin
      if (reset) begin
         header_count_ff  <= 3'd0;
         header_type_ff   <= 8'd0;
         header_major_ff  <= 8'd0;
         header_minor_ff  <= 8'd0;
         header_length_ff <= 16'd0;
         payload_count_ff <= 16'd0;
         error_ff         <= trd_pkg::ERR_NONE;
      end else if (accept) begin
         header_count_ff  <= header_count_in;
         header_type_ff   <= header_type_in;
         header_major_ff  <= header_major_in;
         header_minor_ff  <= header_minor_in;
         header_length_ff <= header_length_in;
         payload_count_ff <= payload_count_in;
         error_ff         <= error_in;
      end
   end

endmodule

FILE: src/trd_skid.sv
// Output register with a skid stage, so the request side never waits on a
// combinational stall path. Depends on trd_pkg for the result struct.
module trd_skid (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_stall,
   input  trd_pkg::result_type   in_data,
   output logic                  out_valid,
   input  logic                  out_stall,
   output trd_pkg::result_type   out_data
);

   logic                out_valid_ff, out_valid_in;
   logic                skid_valid_ff, skid_valid_in;
   trd_pkg::result_type out_ff, out_in;
   trd_pkg::result_type skid_ff, skid_in;
   logic                take;
   logic                in_acc;

   assign take   = out_valid_ff & ~out_stall;
   assign in_acc = in_valid & ~skid_valid_ff;

   // Refill the output from the skid stage first, then from the request
   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_in        = out_ff;
      skid_in       = skid_ff;
      if (take || !out_valid_ff) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            out_in       = in_data;
            out_valid_in = in_acc;
         end
      end else if (in_acc) begin
         skid_in       = in_data;
         skid_valid_in = 1'b1;
      end
   end

   // Hold control state under reset; payload needs none
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign in_stall  = skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_ff;

endmodule

FILE: src/tls_record_deframer.sv
// TLS 1.2 record deframer top level: APB register, core and output skid stage.
// Depends on trd_pkg, trd_core and trd_skid.
//
//   Port group   Direction   Handshake        Moves
//   req_*        in          valid / stall    one stream byte per request
//   rsp_*        out         valid / stall    one result per request
//   APB          in / out    psel / penable   buffer_room at address 0
//
// One request is taken per cycle while req_stall is low; its result is
// registered in the output register, or in the skid stage if that stalls.
// Reset clears the counters, the sticky error and buffer_room to 18480.
// req_stall is registered: it rises only once the skid stage holds a result
// behind a stalled output register.
module tls_record_deframer #(
   parameter int ROOM_MARGIN = 48
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_stream_byte,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_event_res,
   output logic [7:0]  rsp_payload_byte,
   output logic [1:0]  rsp_record_type,
   output logic [15:0] rsp_record_length,
   output logic        rsp_last,
   output logic [1:0]  rsp_error_code,
   // configuration port
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic [16:0]         buffer_room_ff;
   logic                cfg_write;
   logic                req_accept;
   trd_pkg::result_type core_result;
   trd_pkg::result_type rsp_data;

   // Write the buffer room register
   assign pready    = 1'b1;
   assign cfg_write = psel & penable & pwrite & (paddr[2] == trd_pkg::REG_BUFFER_ROOM);

   always_ff @(posedge clock) begin
      if (reset) begin
         buffer_room_ff <= trd_pkg::ROOM_RESET;
      end else if (cfg_write) begin
         buffer_room_ff <= pwdata[trd_pkg::ROOM_WIDTH-1:0];
      end
   end

   // Read back
   always_comb begin
      prdata = 32'd0;
      if (paddr[2] == trd_pkg::REG_BUFFER_ROOM) begin
         prdata = {15'd0, buffer_room_ff};
      end
   end

   assign req_accept = req_valid & ~req_stall;

   trd_core #(
      .ROOM_MARGIN (ROOM_MARGIN)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .accept      (req_accept),
      .stream_byte (req_stream_byte),
      .buffer_room (buffer_room_ff),
      .result      (core_result)
   );

   trd_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_stall  (req_stall),
      .in_data   (core_result),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (rsp_data)
   );

   assign rsp_event_res     = rsp_data.event_res;
   assign rsp_payload_byte  = rsp_data.payload_byte;
   assign rsp_record_type   = rsp_data.record_type;
   assign rsp_record_length = rsp_data.record_length;
   assign rsp_last          = rsp_data.last;
   assign rsp_error_code    = rsp_data.error_code;

endmodule

FILE: test/deframe_checker.sv
// Result checker for the TLS record deframer: tracks header and payload state,
// predicts one result per accepted request and compares it with the result channel.
// Depends on trd_pkg; also watches the APB port to follow writes of buffer_room.
module deframe_checker #(
   parameter int ROOM_MARGIN = 48
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_stream_byte,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [1:0]  rsp_event_res,
   input  logic [7:0]  rsp_payload_byte,
   input  logic [1:0]  rsp_record_type,
   input  logic [15:0] rsp_record_length,
   input  logic        rsp_last,
   input  logic [1:0]  rsp_error_code,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   input  logic        pready,
   input  logic        closing,
   output int          mismatches,
   output int          pending
);

   // deframer state as the block should hold it
   logic [16:0] room;
   logic [2:0]  hdr_count;
   logic [7:0]  hdr_type;
   logic [7:0]  hdr_major;
   logic [7:0]  hdr_minor;
   logic [15:0] hdr_length;
   logic [15:0] pay_count;
   logic [1:0]  err_latched;

   trd_pkg::result_type expected_results[$];
   trd_pkg::result_type predicted;
   trd_pkg::result_type observed;
   logic                closed;

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $time, what);
      mismatches++;
   endtask

   task automatic compare_field(input string name, input logic [15:0] got,
                                input logic [15:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %0h, expected %0h", name, got, want));
   endtask

   // content type index as shown on the result, low two bits of type - 0x14
   function automatic logic [1:0] type_index();
      logic [7:0] offset;
      offset = hdr_type - trd_pkg::TYPE_MIN;
      return offset[1:0];
   endfunction

   // type first, then version, then buffer room
   function automatic logic [1:0] header_fault();
      if (hdr_type < trd_pkg::TYPE_MIN || hdr_type > trd_pkg::TYPE_MAX)
         return trd_pkg::ERR_TYPE;
      if (hdr_major < trd_pkg::VERSION_MAJ ||
          (hdr_major == trd_pkg::VERSION_MAJ && hdr_minor < trd_pkg::VERSION_MIN))
         return trd_pkg::ERR_VERSION;
      if (int'(hdr_length) + ROOM_MARGIN >= int'(room))
         return trd_pkg::ERR_OVERFLOW;
      return trd_pkg::ERR_NONE;
   endfunction

   // advance the deframer by one stream byte and work out its result
   task automatic deframe(input logic [7:0] b, output trd_pkg::result_type r);
      logic [1:0] fault;
      r = '0;
      // hold the sticky error and ignore the byte
      if (err_latched != trd_pkg::ERR_NONE) begin
         r.event_res     = trd_pkg::EV_ERROR;
         r.record_type   = type_index();
         r.record_length = hdr_length;
         r.error_code    = err_latched;
         return;
      end
      if (hdr_count < trd_pkg::HEADER_BYTES) begin
         case (hdr_count)
            3'd0: hdr_type = b;
            3'd1: hdr_major = b;
            3'd2: hdr_minor = b;
            3'd3: hdr_length = {b, 8'h00};
            default: hdr_length[7:0] = b;
         endcase
         hdr_count++;
         r.event_res = trd_pkg::EV_HEADER;
         if (hdr_count < trd_pkg::HEADER_BYTES)
            return;
         r.record_type   = type_index();
         r.record_length = hdr_length;
         fault = header_fault();
         if (fault != trd_pkg::ERR_NONE) begin
            err_latched  = fault;
            r.event_res  = trd_pkg::EV_ERROR;
            r.error_code = fault;
            return;
         end
         pay_count = '0;
         // an empty record ends on its header
         if (hdr_length == 16'd0) begin
            hdr_count = '0;
            r.last    = 1'b1;
         end
         return;
      end
      pay_count++;
      r.event_res     = trd_pkg::EV_PAYLOAD;
      r.payload_byte  = b;
      r.record_type   = type_index();
      r.record_length = hdr_length;
      if (pay_count >= hdr_length) begin
         hdr_count = '0;
         pay_count = '0;
         r.last    = 1'b1;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         room        = trd_pkg::ROOM_RESET;
         hdr_count   = '0;
         hdr_type    = '0;
         hdr_major   = '0;
         hdr_minor   = '0;
         hdr_length  = '0;
         pay_count   = '0;
         err_latched = trd_pkg::ERR_NONE;
         mismatches  = 0;
         closed      = 1'b0;
         expected_results.delete();
         pending <= 0;
      end else begin
         // compare the result taken at this edge with the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            observed = '{rsp_event_res, rsp_payload_byte, rsp_record_type,
                         rsp_record_length, rsp_last, rsp_error_code};
            if (expected_results.size() == 0) begin
               report_mismatch("result with no request outstanding");
            end else begin
               predicted = expected_results.pop_front();
               compare_field("event_res", 16'(observed.event_res),
                             16'(predicted.event_res));
               compare_field("payload_byte", 16'(observed.payload_byte),
                             16'(predicted.payload_byte));
               compare_field("record_type", 16'(observed.record_type),
                             16'(predicted.record_type));
               compare_field("record_length", observed.record_length,
                             predicted.record_length);
               compare_field("last", 16'(observed.last), 16'(predicted.last));
               compare_field("error_code", 16'(observed.error_code),
                             16'(predicted.error_code));
            end
         end
         // follow register writes
         if (psel && penable && pwrite && pready &&
             paddr == {trd_pkg::REG_BUFFER_ROOM, 2'b00})
            room = pwdata[trd_pkg::ROOM_WIDTH-1:0];
         // predict the result of the request taken at this edge
         if (req_valid && !req_stall) begin
            deframe(req_stream_byte, predicted);
            expected_results.push_back(predicted);
         end
         if (closing && !closed) begin
            closed = 1'b1;
            if (expected_results.size() != 0)
               report_mismatch($sformatf("%0d results never arrived",
                                         expected_results.size()));
         end
         pending <= expected_results.size();
      end
   end

endmodule

FILE: test/tls_record_deframer_tb.sv
// Testbench top for tls_record_deframer: clock, reset, record stimulus and verdict.
// Depends on trd_pkg, the deframer RTL and deframe_checker, which does the checking.
module tls_record_deframer_tb;

   localparam int MARGIN      = 48;
   localparam int CYCLE_LIMIT = 300000;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_stream_byte;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_event_res;
   logic [7:0]  rsp_payload_byte;
   logic [1:0]  rsp_record_type;
   logic [15:0] rsp_record_length;
   logic        rsp_last;
   logic [1:0]  rsp_error_code;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   logic        closing;
   logic        steady;
   int          mismatches;
   int          pending;
   int          accepted = 0;
   int          cycle_count = 0;

   tls_record_deframer #(.ROOM_MARGIN(MARGIN)) uut (.*);

   deframe_checker #(.ROOM_MARGIN(MARGIN)) u_checker (.*);

   always #10 clock = ~clock;

   // stall the result channel now and then, never during the steady stretch
   always @(posedge clock) rsp_stall <= !steady && ($urandom_range(99) < 6);

   // give up on a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // offer one stream byte, occasionally dropping req_valid first
   task automatic send_byte(input logic [7:0] b);
      if (!steady && $urandom_range(99) < 6) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_stream_byte <= b;
      do @(posedge clock); while (req_stall);
      accepted++;
   endtask

   task automatic send_header(input logic [7:0] ctype, input logic [7:0] major,
                              input logic [7:0] minor, input logic [15:0] len);
      send_byte(ctype);
      send_byte(major);
      send_byte(minor);
      send_byte(len[15:8]);
      send_byte(len[7:0]);
   endtask

   // well-formed record that fits the given room, mostly short
   task automatic send_random_record(input logic [16:0] room);
      int unsigned cap;
      int unsigned len;
      int unsigned pick;
      logic [7:0]  major;
      logic [7:0]  minor;
      cap = room - (MARGIN + 1);
      if (cap > 40)
         cap = 40;
      pick = $urandom_range(9);
      if (pick == 0)
         len = cap;
      else if (pick == 1)
         len = $urandom_range(cap);
      else
         len = $urandom_range(cap < 12 ? cap : 12);
      if ($urandom_range(3) == 0) begin
         major = 8'($urandom_range(4, 255));
         minor = 8'($urandom_range(255));
      end else begin
         major = trd_pkg::VERSION_MAJ;
         minor = 8'($urandom_range(trd_pkg::VERSION_MIN, 255));
      end
      send_header(trd_pkg::TYPE_MIN + 8'($urandom_range(3)), major, minor, 16'(len));
      repeat (len) send_byte(8'($urandom));
   endtask

   // hold off the sender until every result is back
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   task automatic write_room(input logic [16:0] value);
      repeat (4) @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {trd_pkg::REG_BUFFER_ROOM, 2'b00};
      pwdata  <= 32'(value);
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   initial begin
      int          phase;
      logic [16:0] room;
      logic [7:0]  ctype;
      logic [7:0]  major;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_stream_byte = '0;
      psel            = 1'b0;
      penable         = 1'b0;
      pwrite          = 1'b0;
      paddr           = '0;
      pwdata          = '0;
      closing         = 1'b0;
      steady          = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed records at the reset buffer room
      send_header(trd_pkg::TYPE_MIN, trd_pkg::VERSION_MAJ, trd_pkg::VERSION_MIN, 16'd0);
      send_header(trd_pkg::TYPE_MAX, 8'hFF, 8'h00, 16'd2);
      send_byte(8'h00);
      send_byte(8'hFF);
      send_header(trd_pkg::TYPE_MIN + 8'd1, trd_pkg::VERSION_MAJ, 8'hFF, 16'd1);
      send_byte(8'hA5);
      send_header(trd_pkg::TYPE_MIN + 8'd2, 8'd4, 8'd0, 16'd0);

      // random records over several room settings: widest, tight, empty only, steady
      for (phase = 0; phase < 4; phase++) begin
         wait_drained();
         case (phase)
            0: room = {trd_pkg::ROOM_WIDTH{1'b1}};
            1: room = 17'(MARGIN + 12);
            2: room = 17'(MARGIN + 1);
            default: room = 17'($urandom_range(400, 131071));
         endcase
         write_room(room);
         steady = (phase == 3);
         repeat (8) send_random_record(room);
      end
      steady = 1'b0;

      // close with one bad header; the error then sticks for the rest of the run
      wait_drained();
      write_room('0);
      case ($urandom_range(2))
         0: begin
            do ctype = 8'($urandom);
            while (ctype >= trd_pkg::TYPE_MIN && ctype <= trd_pkg::TYPE_MAX);
            send_header(ctype, 8'($urandom_range(2)), 8'($urandom), 16'($urandom));
         end
         1: begin
            major = 8'($urandom_range(trd_pkg::VERSION_MAJ));
            send_header(trd_pkg::TYPE_MIN + 8'($urandom_range(3)), major,
                        major == trd_pkg::VERSION_MAJ ? 8'($urandom_range(2))
                                                      : 8'($urandom),
                        16'($urandom));
         end
         default: begin
            send_header(trd_pkg::TYPE_MIN + 8'($urandom_range(3)), trd_pkg::VERSION_MAJ,
                        8'($urandom_range(trd_pkg::VERSION_MIN, 255)),
                        $urandom_range(1) ? 16'hFFFF : 16'($urandom));
         end
      endcase
      repeat (20) send_byte(8'($urandom));

      // drain, settle, then let the checker count anything left over
      wait_drained();
      repeat (8) @(posedge clock);
      closing <= 1'b1;
      repeat (2) @(posedge clock);
      if (mismatches == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

FILE: tls_record_deframer.f
src/trd_pkg.sv
src/trd_core.sv
src/trd_skid.sv
src/tls_record_deframer.sv
test/deframe_checker.sv
test/tls_record_deframer_tb.sv
